### rtl/tiny_cpu_execute_top_assert.svh
// assertion macros for the tiny cpu execute block
// used by tiny_cpu_execute_top; no other dependencies
`ifndef TINY_CPU_EXECUTE_TOP_ASSERT_SVH
`define TINY_CPU_EXECUTE_TOP_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication, checked out of reset
`define TCE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tce assertion failed");
// next-cycle implication, checked out of reset
`define TCE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tce assertion failed");
`else
`define TCE_ASSERT_IMP(label, ante, cons)
`define TCE_ASSERT_NXT(label, ante, cons)
`endif
`endif

### rtl/tce_pkg.sv
// shared types and constants for the tiny cpu execute block
// used by tce_alu and tiny_cpu_execute_top
package tce_pkg;

  // data memory geometry
  localparam int DATA_WORDS = 256;
  localparam int DMEM_AW    = $clog2(DATA_WORDS);
  localparam logic [8:0] DATA_WORDS_W = 9'(DATA_WORDS);

  // instruction field positions
  localparam int OP_LSB = 11;

  // opcodes; codes 16 to 31 are no-ops
  typedef enum logic [4:0] {
    OP_MOV = 5'd0,
    OP_ADD = 5'd1,
    OP_SUB = 5'd2,
    OP_AND = 5'd3,
    OP_OR  = 5'd4,
    OP_SL  = 5'd5,
    OP_SR  = 5'd6,
    OP_SRA = 5'd7,
    OP_LDL = 5'd8,
    OP_LDH = 5'd9,
    OP_CMP = 5'd10,
    OP_JE  = 5'd11,
    OP_JMP = 5'd12,
    OP_LD  = 5'd13,
    OP_ST  = 5'd14,
    OP_HLT = 5'd15
  } op_t;

  // execute result handed from the alu to the write-back logic
  typedef struct packed {
    logic        wr;
    logic [15:0] val;
    logic        mw;
    logic        flag;
    logic [7:0]  pc;
    logic        halt;
  } exec_res_t;

endpackage

### rtl/tce_alu.sv
// execute stage of the tiny cpu: decode, alu, branch and state update
// depends on tce_pkg
module tce_alu (
  input  logic [15:0]       instr,
  input  logic [15:0]       a,
  input  logic [15:0]       b,
  input  logic [15:0]       ld_data,
  input  logic              flag,
  input  logic [7:0]        pc,
  input  logic              halt,
  output tce_pkg::exec_res_t res
);

  logic [4:0] op;
  logic [7:0] imm;
  logic       in_range;

  assign op       = instr[15:tce_pkg::OP_LSB];
  assign imm      = instr[7:0];
  assign in_range = ({1'b0, imm} < tce_pkg::DATA_WORDS_W);

  // decode and execute one instruction
  always_comb begin
    res.wr   = 1'b0;
    res.val  = 16'h0000;
    res.mw   = 1'b0;
    res.flag = flag;
    res.pc   = pc;
    res.halt = halt;
    if (!halt) begin
      res.pc = pc + 8'd1;
      unique case (op)
        tce_pkg::OP_MOV: begin res.val = b; res.wr = 1'b1; end
        tce_pkg::OP_ADD: begin res.val = a + b; res.wr = 1'b1; end
        tce_pkg::OP_SUB: begin res.val = a - b; res.wr = 1'b1; end
        tce_pkg::OP_AND: begin res.val = a & b; res.wr = 1'b1; end
        tce_pkg::OP_OR:  begin res.val = a | b; res.wr = 1'b1; end
        tce_pkg::OP_SL:  begin res.val = {a[14:0], 1'b0}; res.wr = 1'b1; end
        tce_pkg::OP_SR:  begin res.val = {1'b0, a[15:1]}; res.wr = 1'b1; end
        tce_pkg::OP_SRA: begin res.val = {a[15], a[15:1]}; res.wr = 1'b1; end
        tce_pkg::OP_LDL: begin res.val = {a[15:8], imm}; res.wr = 1'b1; end
        tce_pkg::OP_LDH: begin res.val = {imm, a[7:0]}; res.wr = 1'b1; end
        tce_pkg::OP_CMP: res.flag = (a == b);
        tce_pkg::OP_JE: begin
          if (flag) res.pc = imm;
        end
        tce_pkg::OP_JMP: res.pc = imm;
        tce_pkg::OP_LD: begin
          res.val = in_range ? ld_data : 16'h0000;
          res.wr  = 1'b1;
        end
        tce_pkg::OP_ST:  res.mw = in_range;
        tce_pkg::OP_HLT: res.halt = 1'b1;
        default: ;
      endcase
    end
  end

endmodule

### rtl/tiny_cpu_execute_top.sv
// top level of the tiny cpu execute block: register file, data memory, pipeline
// depends on tce_pkg, tce_alu and tiny_cpu_execute_top_assert.svh
//
// usage:
//   input channel carries one 16-bit instruction word per transaction
//   (in_valid / in_stall); the result channel returns one transaction per
//   instruction with the next fetch address, register write, memory store,
//   equal flag and halt mark (out_valid / out_stall).
//   an accepted instruction is registered into the execute stage, and its
//   result is then registered on out_*. throughput: one instruction per cycle
//   while the receiver does not stall. register file and data memory are
//   read first (synchronous reads, forwarded from the write-back of the
//   previous instruction); the execute stage then executes, writes back and
//   loads the output register.
//   reset clears pc, flag, halt mark and the per-entry valid bits of both
//   memories, so unwritten entries read as zero; no clearing pass is needed
//   and the block accepts right after reset.
//   when the receiver stalls, the result holds on out_*, one more
//   instruction waits in the execute stage and then in_stall rises.
//   after a halt instruction, further words are consumed but change nothing.
`include "tiny_cpu_execute_top_assert.svh"

module tiny_cpu_execute_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        in_instruction,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_fetch_address,
  output logic               out_halted,
  output logic               out_reg_write,
  output logic [2:0]         out_reg_index,
  output logic signed [15:0] out_reg_value,
  output logic               out_mem_write,
  output logic [7:0]         out_mem_address,
  output logic signed [15:0] out_mem_data,
  output logic               out_flag_equal
);

  // memories
  logic [15:0] rf_mem [8];
  logic [15:0] dm_mem [tce_pkg::DATA_WORDS];
  logic [7:0]  rf_vld_r;
  logic [tce_pkg::DATA_WORDS-1:0] dm_vld_r;

  // handshake and stage control
  logic accept;
  logic s1_adv;
  logic s1_vld_r;
  logic out_vld_r;

  // execute stage registers
  logic [15:0] s1_instr_r;
  logic [15:0] rf_a_r, rf_b_r, dm_rd_r;
  logic        a_vld_r, b_vld_r, d_vld_r;
  logic        fwd_a_r, fwd_b_r, fwd_d_r;
  logic [15:0] rf_wdata_r, dm_wdata_r;

  // architectural state
  logic [7:0] pc_r;
  logic       flag_r;
  logic       halt_r;

  // read addresses of the incoming instruction
  logic [2:0]                  in_ra, in_rb;
  logic [tce_pkg::DMEM_AW-1:0] in_da;

  // write-back of the instruction in execute
  logic [2:0]                  s1_ra;
  logic [tce_pkg::DMEM_AW-1:0] s1_da;
  logic                        rf_we, dm_we;
  logic [15:0]                 op_a, op_b, op_d;
  tce_pkg::exec_res_t          res;

  assign in_ra = in_instruction[10:8];
  assign in_rb = in_instruction[7:5];
  assign in_da = in_instruction[tce_pkg::DMEM_AW-1:0];
  assign s1_ra = s1_instr_r[10:8];
  assign s1_da = s1_instr_r[tce_pkg::DMEM_AW-1:0];

  // pipeline flow control
  assign s1_adv   = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = s1_vld_r && !s1_adv;
  assign accept   = in_valid && !in_stall;
  assign rf_we    = s1_adv && res.wr;
  assign dm_we    = s1_adv && res.mw;

  // register file: one write, two registered reads
  always_ff @(posedge clk) begin
    if (rf_we) rf_mem[s1_ra] <= res.val;
    if (accept) begin
      rf_a_r <= rf_mem[in_ra];
      rf_b_r <= rf_mem[in_rb];
    end
  end

  // data memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (dm_we) dm_mem[s1_da] <= op_a;
    if (accept) dm_rd_r <= dm_mem[in_da];
  end

  // valid bits: unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
      dm_vld_r <= '0;
    end else begin
      if (rf_we) rf_vld_r[s1_ra] <= 1'b1;
      if (dm_we) dm_vld_r[s1_da] <= 1'b1;
    end
  end

  // read side bookkeeping: valid bits and forwarding from the same-cycle write
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_instr_r <= in_instruction;
      a_vld_r    <= rf_vld_r[in_ra];
      b_vld_r    <= rf_vld_r[in_rb];
      d_vld_r    <= dm_vld_r[in_da];
      fwd_a_r    <= rf_we && (s1_ra == in_ra);
      fwd_b_r    <= rf_we && (s1_ra == in_rb);
      fwd_d_r    <= dm_we && (s1_da == in_da);
      rf_wdata_r <= res.val;
      dm_wdata_r <= op_a;
    end
  end

  // operand selection
  always_comb begin
    op_a = fwd_a_r ? rf_wdata_r : (a_vld_r ? rf_a_r : 16'h0000);
    op_b = fwd_b_r ? rf_wdata_r : (b_vld_r ? rf_b_r : 16'h0000);
    op_d = fwd_d_r ? dm_wdata_r : (d_vld_r ? dm_rd_r : 16'h0000);
  end

  // execute
  tce_alu u_alu (
    .instr   (s1_instr_r),
    .a       (op_a),
    .b       (op_b),
    .ld_data (op_d),
    .flag    (flag_r),
    .pc      (pc_r),
    .halt    (halt_r),
    .res     (res)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      pc_r      <= '0;
      flag_r    <= 1'b0;
      halt_r    <= 1'b0;
    end else begin
      s1_vld_r  <= accept || (s1_vld_r && !s1_adv);
      out_vld_r <= s1_adv || (out_vld_r && out_stall);
      if (s1_adv) begin
        pc_r   <= res.pc;
        flag_r <= res.flag;
        halt_r <= res.halt;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_fetch_address <= res.pc;
      out_halted        <= res.halt;
      out_reg_write     <= res.wr;
      out_reg_index     <= res.wr ? s1_ra : 3'd0;
      out_reg_value     <= res.wr ? res.val : 16'sh0000;
      out_mem_write     <= res.mw;
      out_mem_address   <= res.mw ? s1_instr_r[7:0] : 8'd0;
      out_mem_data      <= res.mw ? op_a : 16'sh0000;
      out_flag_equal    <= res.flag;
    end
  end

  assign out_valid = out_vld_r;

  // checks
  `TCE_ASSERT_NXT(a_halt_sticky, halt_r, halt_r)
  `TCE_ASSERT_NXT(a_halt_no_write, s1_adv && halt_r, !out_reg_write && !out_mem_write)
  `TCE_ASSERT_IMP(a_one_write, out_vld_r, !(out_reg_write && out_mem_write))
  `TCE_ASSERT_IMP(a_stall_needs_item, in_stall, s1_vld_r)

endmodule
